/* hw/rtl/car_pkg.sv */
// Package: shared types, codes and defaults for the counter automaton recognizer.
package car_pkg;

   // Default sizes
   localparam int TABLE_DEPTH_DEFAULT  = 1024;
   localparam int COUNTER_BITS_DEFAULT = 16;

   // Field widths fixed by the item format
   localparam int OPCODE_BITS  = 2;
   localparam int TADDR_BITS   = 10;
   localparam int WORD_BITS    = 11;
   localparam int SYMBOL_BITS  = 8;
   localparam int VERDICT_BITS = 4;
   localparam int STATE_BITS   = 10;
   localparam int COUNT_BITS   = 16;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 48;

   // Item kinds
   localparam logic [OPCODE_BITS-1:0] OP_WRITE  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_SYMBOL = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_END    = 2'd2;

   // Verdict codes
   localparam logic [VERDICT_BITS-1:0] VERDICT_RUNNING   = 4'd0;
   localparam logic [VERDICT_BITS-1:0] VERDICT_ACCEPTED  = 4'd1;
   localparam logic [VERDICT_BITS-1:0] VERDICT_NO_TRANS  = 4'd2;
   localparam logic [VERDICT_BITS-1:0] VERDICT_C1_UNDER  = 4'd3;
   localparam logic [VERDICT_BITS-1:0] VERDICT_C2_UNDER  = 4'd4;
   localparam logic [VERDICT_BITS-1:0] VERDICT_C1_NZ     = 4'd5;
   localparam logic [VERDICT_BITS-1:0] VERDICT_C2_NZ     = 4'd6;
   localparam logic [VERDICT_BITS-1:0] VERDICT_BOTH_NZ   = 4'd7;
   localparam logic [VERDICT_BITS-1:0] VERDICT_NOT_FINAL = 4'd8;

   // Table word values with a meaning
   localparam logic [WORD_BITS-1:0] WORD_MODE_ONE = 11'd1;
   localparam logic [WORD_BITS-1:0] WORD_MODE_TWO = 11'd2;
   localparam logic [WORD_BITS-1:0] WORD_INC      = 11'd1;
   localparam logic [WORD_BITS-1:0] WORD_DEC      = 11'h7FF;

   // Fixed table locations
   localparam int ADDR_MODE   = 0;
   localparam int ADDR_START  = 1;
   localparam int ADDR_NFINAL = 2;
   localparam int ADDR_FINALS = 3;

   // Word offsets inside a transition tuple
   localparam int OFS_NEXT = 1;
   localparam int OFS_OP1  = 3;
   localparam int OFS_OP2  = 5;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_ONE,
      MODE_TWO
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYM_CNT,
      ST_SYM_MATCH,
      ST_OP1,
      ST_OP2,
      ST_NEXT,
      ST_END_CHK,
      ST_END_NF,
      ST_END_SCAN,
      ST_FINISH
   } fsm_state_type;

endpackage

/* hw/rtl/counter_automaton_recognizer.sv */
// Top level: table-driven finite and counter automaton recognizer.
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tuser: opcode; tdata: address, value, symbol
//   rsp_      out        rsp_tvalid/tready    tdata: verdict, state, count one, count two
//
// Steps: a table write is stored on acceptance; a symbol reads the transition count, compares
// tuples, reads each counter operation and commits a taken transition, or skips to the result
// on a rejected run; an end item ends when the reject code or a counter decides, else reads the
// final-state count and compares final states. The table memory reads one word per cycle.
// Reset clears the run and the control state; table contents stay undefined until written.
// TABLE_DEPTH must be a power of two, which the block does not check; addresses wrap modulo it.
// A result held by a low rsp_tready does not block acceptance of the next item; that item
// waits in its final cycle until the output register frees.
module counter_automaton_recognizer #(
   parameter int TABLE_DEPTH  = car_pkg::TABLE_DEPTH_DEFAULT,
   parameter int COUNTER_BITS = car_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] opcode
   input  logic [car_pkg::OPCODE_BITS-1:0]     req_tuser,
   // [9:0] table_address, [20:10] table_value, [28:21] symbol, [31:29] zero
   input  logic [car_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [3:0] verdict, [13:4] current_state, [29:14] count_one, [45:30] count_two, [47:46] zero
   output logic [car_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import car_pkg::*;

   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

   // Table memory
   logic [WORD_BITS-1:0] table_mem [TABLE_DEPTH];
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_wr_addr;
   logic [ADDR_BITS-1:0] mem_rd_addr;
   logic [WORD_BITS-1:0] rd_data_ff;

   // Control and run registers
   fsm_state_type           state_ff, state_in;
   logic [OPCODE_BITS-1:0]  op_ff, op_in;
   logic [SYMBOL_BITS-1:0]  sym_ff, sym_in;
   logic [STATE_BITS-1:0]   cur_state_ff, cur_state_in;
   logic [COUNTER_BITS-1:0] cnt1_ff, cnt1_in;
   logic [COUNTER_BITS-1:0] cnt2_ff, cnt2_in;
   logic [COUNTER_BITS-1:0] tmp1_ff, tmp1_in;
   logic [COUNTER_BITS-1:0] tmp2_ff, tmp2_in;
   logic                    started_ff, started_in;
   logic [VERDICT_BITS-1:0] reject_ff, reject_in;
   logic [VERDICT_BITS-1:0] verdict_ff, verdict_in;
   mode_type                mode_ff, mode_in;
   logic [STATE_BITS-1:0]   start_ff, start_in;
   logic [ADDR_BITS-1:0]    ptr_ff, ptr_in;
   logic [STATE_BITS-1:0]   remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Request fields
   logic [TADDR_BITS-1:0]  req_addr;
   logic [WORD_BITS-1:0]   req_value;
   logic [SYMBOL_BITS-1:0] req_symbol;
   logic                   req_fire;

   // Shared decisions
   logic                   out_free;
   logic                   word_nonpos;
   logic                   sym_hit;
   logic                   final_hit;
   logic                   op_dec;
   logic                   op_inc;
   logic                   tmp1_under;
   logic                   tmp2_under;
   logic                   last_entry;
   logic                   run_rejected;
   logic [ADDR_BITS-1:0]   tuple_step;
   logic [ADDR_BITS-1:0]   state_addr;

   assign req_addr   = req_tdata[9:0];
   assign req_value  = req_tdata[20:10];
   assign req_symbol = req_tdata[28:21];
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign word_nonpos  = rd_data_ff[WORD_BITS-1] || (rd_data_ff[9:0] == '0);
   assign sym_hit      = (rd_data_ff == {3'b000, sym_ff});
   assign final_hit    = (rd_data_ff == {1'b0, cur_state_ff});
   assign op_inc       = (rd_data_ff == WORD_INC);
   assign op_dec       = (rd_data_ff == WORD_DEC);
   assign tmp1_under   = op_dec && (tmp1_ff == '0);
   assign tmp2_under   = op_dec && (tmp2_ff == '0);
   assign last_entry   = (remain_ff == STATE_BITS'(1));
   assign run_rejected = started_ff && (reject_ff != VERDICT_RUNNING);
   assign state_addr   = ADDR_BITS'(cur_state_ff);
   assign mem_wr_addr  = ADDR_BITS'(req_addr);

   // Tuple length follows the mode
   always_comb begin
      case (mode_ff)
         MODE_ONE: tuple_step = ADDR_BITS'(4);
         MODE_TWO: tuple_step = ADDR_BITS'(6);
         default:  tuple_step = ADDR_BITS'(2);
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_SYMBOL) begin
                  state_in = run_rejected ? ST_FINISH : ST_SYM_CNT;
               end else if (req_tuser == OP_END) begin
                  state_in = ST_END_CHK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SYM_CNT: begin
            state_in = word_nonpos ? ST_FINISH : ST_SYM_MATCH;
         end
         ST_SYM_MATCH: begin
            if (sym_hit) begin
               state_in = (mode_ff == MODE_NONE) ? ST_NEXT : ST_OP1;
            end else if (last_entry) begin
               state_in = ST_FINISH;
            end
         end
         ST_OP1: begin
            if (tmp1_under) begin
               state_in = ST_FINISH;
            end else begin
               state_in = (mode_ff == MODE_TWO) ? ST_OP2 : ST_NEXT;
            end
         end
         ST_OP2: begin
            state_in = tmp2_under ? ST_FINISH : ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_FINISH;
         end
         ST_END_CHK: begin
            if (reject_ff != VERDICT_RUNNING) begin
               state_in = ST_FINISH;
            end else if (mode_ff == MODE_ONE && cnt1_ff != '0) begin
               state_in = ST_FINISH;
            end else if (mode_ff == MODE_TWO && (cnt1_ff != '0 || cnt2_ff != '0)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_END_NF;
            end
         end
         ST_END_NF: begin
            state_in = word_nonpos ? ST_FINISH : ST_END_SCAN;
         end
         ST_END_SCAN: begin
            if (final_hit || last_entry) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory port and result register
   always_comb begin
      op_in        = op_ff;
      sym_in       = sym_ff;
      cur_state_in = cur_state_ff;
      cnt1_in      = cnt1_ff;
      cnt2_in      = cnt2_ff;
      tmp1_in      = tmp1_ff;
      tmp2_in      = tmp2_ff;
      started_in   = started_ff;
      reject_in    = reject_ff;
      verdict_in   = verdict_ff;
      mode_in      = mode_ff;
      start_in     = start_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_rd_addr  = ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_tuser;
               sym_in = req_symbol;
               if (req_tuser == OP_WRITE) begin
                  // Store the word and keep copies of the mode and start words
                  mem_we = 1'b1;
                  if (mem_wr_addr == ADDR_BITS'(ADDR_MODE)) begin
                     if (req_value == WORD_MODE_ONE) begin
                        mode_in = MODE_ONE;
                     end else if (req_value == WORD_MODE_TWO) begin
                        mode_in = MODE_TWO;
                     end else begin
                        mode_in = MODE_NONE;
                     end
                  end
                  if (mem_wr_addr == ADDR_BITS'(ADDR_START)) begin
                     start_in = req_value[9:0];
                  end
               end else if ((req_tuser == OP_SYMBOL || req_tuser == OP_END) &&
                            !started_ff) begin
                  // Open a new run
                  started_in   = 1'b1;
                  cur_state_in = start_ff;
                  cnt1_in      = '0;
                  cnt2_in      = '0;
                  reject_in    = VERDICT_RUNNING;
               end
               mem_rd_addr = ADDR_BITS'(cur_state_in);
            end
         end
         ST_SYM_CNT: begin
            // Transition count of the current state
            if (word_nonpos) begin
               reject_in = VERDICT_NO_TRANS;
            end else begin
               remain_in = rd_data_ff[9:0];
            end
            ptr_in      = state_addr + ADDR_BITS'(1);
            mem_rd_addr = state_addr + ADDR_BITS'(1);
         end
         ST_SYM_MATCH: begin
            // Compare the tuple symbol, advance to the next tuple on a miss, reject after the last one
            if (sym_hit) begin
               tmp1_in = cnt1_ff;
               tmp2_in = cnt2_ff;
               if (mode_ff == MODE_NONE) begin
                  mem_rd_addr = ptr_ff + ADDR_BITS'(OFS_NEXT);
               end else begin
                  mem_rd_addr = ptr_ff + ADDR_BITS'(OFS_OP1);
               end
            end else if (last_entry) begin
               reject_in = VERDICT_NO_TRANS;
            end else begin
               remain_in   = remain_ff - STATE_BITS'(1);
               ptr_in      = ptr_ff + tuple_step;
               mem_rd_addr = ptr_ff + tuple_step;
            end
         end
         ST_OP1: begin
            if (tmp1_under) begin
               reject_in = VERDICT_C1_UNDER;
            end else begin
               if (op_dec) begin
                  tmp1_in = tmp1_ff - COUNTER_BITS'(1);
               end else if (op_inc && tmp1_ff != '1) begin
                  tmp1_in = tmp1_ff + COUNTER_BITS'(1);
               end
               if (mode_ff == MODE_TWO) begin
                  mem_rd_addr = ptr_ff + ADDR_BITS'(OFS_OP2);
               end else begin
                  mem_rd_addr = ptr_ff + ADDR_BITS'(OFS_NEXT);
               end
            end
         end
         ST_OP2: begin
            if (tmp2_under) begin
               reject_in = VERDICT_C2_UNDER;
            end else begin
               if (op_dec) begin
                  tmp2_in = tmp2_ff - COUNTER_BITS'(1);
               end else if (op_inc && tmp2_ff != '1) begin
                  tmp2_in = tmp2_ff + COUNTER_BITS'(1);
               end
               mem_rd_addr = ptr_ff + ADDR_BITS'(OFS_NEXT);
            end
         end
         ST_NEXT: begin
            // Commit the transition
            cur_state_in = rd_data_ff[9:0];
            cnt1_in      = tmp1_ff;
            cnt2_in      = tmp2_ff;
         end
         ST_END_CHK: begin
            if (reject_ff != VERDICT_RUNNING) begin
               verdict_in = reject_ff;
            end else if (mode_ff == MODE_ONE && cnt1_ff != '0) begin
               verdict_in = VERDICT_C1_NZ;
            end else if (mode_ff == MODE_TWO && cnt1_ff != '0 && cnt2_ff != '0) begin
               verdict_in = VERDICT_BOTH_NZ;
            end else if (mode_ff == MODE_TWO && cnt1_ff != '0) begin
               verdict_in = VERDICT_C1_NZ;
            end else if (mode_ff == MODE_TWO && cnt2_ff != '0) begin
               verdict_in = VERDICT_C2_NZ;
            end
            mem_rd_addr = ADDR_BITS'(ADDR_NFINAL);
         end
         ST_END_NF: begin
            // Number of final states
            if (word_nonpos) begin
               verdict_in = VERDICT_NOT_FINAL;
            end else begin
               remain_in = rd_data_ff[9:0];
            end
            ptr_in      = ADDR_BITS'(ADDR_FINALS);
            mem_rd_addr = ADDR_BITS'(ADDR_FINALS);
         end
         ST_END_SCAN: begin
            // Search the final state list
            if (final_hit) begin
               verdict_in = VERDICT_ACCEPTED;
            end else if (last_entry) begin
               verdict_in = VERDICT_NOT_FINAL;
            end else begin
               remain_in   = remain_ff - STATE_BITS'(1);
               ptr_in      = ptr_ff + ADDR_BITS'(1);
               mem_rd_addr = ptr_ff + ADDR_BITS'(1);
            end
         end
         ST_FINISH: begin
            // Hand the result over and close the run after an end item
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, COUNT_BITS'(cnt2_ff), COUNT_BITS'(cnt1_ff), cur_state_ff,
                               (op_ff == OP_END) ? verdict_ff : reject_ff};
               if (op_ff == OP_END) begin
                  started_in   = 1'b0;
                  cur_state_in = '0;
                  cnt1_in      = '0;
                  cnt2_in      = '0;
                  reject_in    = VERDICT_RUNNING;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wr_addr] <= req_value;
      end
      rd_data_ff <= table_mem[mem_rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_state_ff <= '0;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         started_ff   <= 1'b0;
         reject_ff    <= VERDICT_RUNNING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_state_ff <= cur_state_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         started_ff   <= started_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      sym_ff      <= sym_in;
      tmp1_ff     <= tmp1_in;
      tmp2_ff     <= tmp2_in;
      verdict_ff  <= verdict_in;
      mode_ff     <= mode_in;
      start_ff    <= start_in;
      ptr_ff      <= ptr_in;
      remain_ff   <= remain_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A delivered verdict is always a defined code
   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= VERDICT_NOT_FINAL))
      else $error("verdict code out of range");

   // A scan never runs with an exhausted entry count
   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SYM_MATCH || state_ff == ST_END_SCAN) |-> (remain_ff != '0))
      else $error("scan with no entries left");

   // A symbol result carries only running or a symbol reject code
   a_symbol_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && op_ff == OP_SYMBOL) |->
         (reject_ff == VERDICT_RUNNING || reject_ff == VERDICT_NO_TRANS ||
          reject_ff == VERDICT_C1_UNDER || reject_ff == VERDICT_C2_UNDER))
      else $error("bad reject code after symbol");

   // The run is closed once an end result is handed over
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free && op_ff == OP_END) |=>
         (!started_ff && reject_ff == VERDICT_RUNNING && rsp_tvalid))
      else $error("run not closed after end item");

endmodule
